[src/rde_pkg.sv]
// rde_pkg: shared types and codes for the reversible deque engine
// no dependencies
package rde_pkg;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_LOAD    = 3'd1;
  localparam logic [2:0] CMD_REVERSE = 3'd2;
  localparam logic [2:0] CMD_DELETE  = 3'd3;
  localparam logic [2:0] CMD_TAKE    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int FIELD_BITS = 16;
  localparam int REM_BITS   = 7;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [FIELD_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] data;
    logic                  has_data;
    logic [1:0]            status;
    logic [REM_BITS-1:0]   remaining;
  } out_item_t;

  typedef struct packed {
    logic                has_data;
    logic [1:0]          status;
    logic [REM_BITS-1:0] remaining;
  } res_t;

endpackage

[src/reversible_deque_engine.sv]
// reversible_deque_engine: top level of the ring-buffer deque with reverse flag
// depends on rde_pkg, rde_ctrl, rde_store, rde_outq
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item_t  (cmd, value)
//   out      output     out_valid / out_ready  out_item_t (data, has_data, status, remaining)
//
// one command per cycle while the output register can drain; a result passes through the result register
// beside the registered store read, then through the output register
// state updates at the accept edge, the store read lands in the read register beside the result register
// synchronous active-low reset empties the deque and drops both flags
// a stalled output holds one result and one more in the result register
module reversible_deque_engine import rde_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);

  logic                  push;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  res_t                  res;

  assign push = in_valid && in_ready;

  rde_ctrl #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .item  (in_item),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .res   (res)
  );

  rde_store #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rde_outq #(.VALUE_BITS(VALUE_BITS)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .rdata     (rdata),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[src/rde_store.sv]
// rde_store: element ring storage, one write and one registered read port
// depends on nothing
module rde_store #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 16,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rde_ctrl.sv]
// rde_ctrl: head, count and flag registers and per-transaction decode
// depends on rde_pkg
module rde_ctrl import rde_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 16,
  parameter int AW         = $clog2(DEPTH),
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  in_item_t              item,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [VALUE_BITS-1:0] wdata,
  output logic                  re,
  output logic [AW-1:0]         raddr,
  output res_t                  res
);

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          err_r, err_nxt;

  logic [AW:0]   sum_back, sum_last, sum_next;
  logic [AW-1:0] pos_back, pos_last, pos_next;
  logic          empty, full;

  assign empty = (count_r == '0);
  assign full  = ((AW+1)'(count_r) >= DEPTH_W);

  // ring positions: sums stay below twice the depth
  always_comb begin
    sum_back = (AW+1)'(head_r) + (AW+1)'(count_r);
    sum_last = (AW+1)'(head_r) + (AW+1)'(count_r) - (AW+1)'(1);
    sum_next = (AW+1)'(head_r) + (AW+1)'(1);
    pos_back = (sum_back >= DEPTH_W) ? AW'(sum_back - DEPTH_W) : sum_back[AW-1:0];
    pos_last = (sum_last >= DEPTH_W) ? AW'(sum_last - DEPTH_W) : sum_last[AW-1:0];
    pos_next = (sum_next >= DEPTH_W) ? AW'(sum_next - DEPTH_W) : sum_next[AW-1:0];
  end

  always_comb begin
    wdata = '0;
    for (int i = 0; i < VALUE_BITS && i < FIELD_BITS; i++) begin
      wdata[i] = item.value[i];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    err_nxt       = err_r;
    we            = 1'b0;
    waddr         = pos_back;
    re            = 1'b0;
    raddr         = rev_r ? pos_last : head_r;
    res.has_data  = 1'b0;
    res.status    = ST_OK;
    res.remaining = '0;
    if (item.cmd == CMD_CLEAR) begin
      head_nxt  = '0;
      count_nxt = '0;
      rev_nxt   = 1'b0;
      err_nxt   = 1'b0;
    end else if (err_r) begin
      res.status = ST_ERROR;
    end else begin
      case (item.cmd)
        CMD_LOAD: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            we        = push;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_REVERSE: begin
          rev_nxt = !rev_r;
        end
        CMD_DELETE, CMD_TAKE: begin
          if (empty) begin
            if (item.cmd == CMD_DELETE) begin
              err_nxt    = 1'b1;
              res.status = ST_ERROR;
            end else begin
              res.status = ST_EMPTY;
            end
          end else begin
            count_nxt = count_r - CW'(1);
            if (!rev_r) begin
              head_nxt = pos_next;
            end
            if (item.cmd == CMD_TAKE) begin
              re           = push;
              res.has_data = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    for (int i = 0; i < REM_BITS && i < CW; i++) begin
      res.remaining[i] = count_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (push) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[src/rde_outq.sv]
// rde_outq: result register beside the store read port, then the output register
// depends on rde_pkg
module rde_outq import rde_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  res_t                  res,
  input  logic [VALUE_BITS-1:0] rdata,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic      s1_valid_r, s1_valid_nxt;
  res_t      s1_res_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      adv;
  logic [FIELD_BITS-1:0] data_cut;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_comb begin
    data_cut = '0;
    for (int i = 0; i < FIELD_BITS && i < VALUE_BITS; i++) begin
      data_cut[i] = rdata[i];
    end
  end

  always_comb begin
    s1_valid_nxt  = push ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1_res_r <= res;
    end
    if (adv) begin
      out_item_r.data      <= s1_res_r.has_data ? data_cut : '0;
      out_item_r.has_data  <= s1_res_r.has_data;
      out_item_r.status    <= s1_res_r.status;
      out_item_r.remaining <= s1_res_r.remaining;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/rde_checker.sv]
// rde_checker: port-level checks for the reversible deque engine, bound to the top
// depends on rde_pkg and reversible_deque_engine
module rde_checker import rde_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped while stalled");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.has_data |-> out_item.status == ST_OK)
    else $error("taken element with non-ok status");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.has_data |-> out_item.data == '0)
    else $error("data nonzero without element");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_EMPTY |-> out_item.remaining == '0)
    else $error("take from empty with elements held");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (.*);

[bench/tb_reversible_deque_engine.sv]
// tb_reversible_deque_engine: self-checking bench for the reversible deque engine
// drives a directed table then random command sequences, checks each result in order
// depends on rde_pkg and reversible_deque_engine
module tb_reversible_deque_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import rde_pkg::*;

  localparam int DEQUE_DEPTH    = 64;
  localparam int ITEM_TARGET    = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;

  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    in_item_t  item;
    logic      pinned;
    out_item_t want;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  logic [15:0] deque_mem [DEQUE_DEPTH];
  logic [5:0]  base_ptr;
  logic [6:0]  fill_level;
  logic        rev_mode;
  logic        err_latched;

  step_row_t sent_rows [$];
  out_item_t pending_results [$];
  step_row_t directed_rows [24];
  step_row_t cur_row;
  out_item_t cur_pred;
  int        mismatches = 0;
  int        items_sent = 0;
  int        source_run = 0;
  int        sink_run = 0;

  reversible_deque_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic step_row_t mk_row(logic [2:0] c, logic [15:0] v, logic p,
                                       logic [15:0] d, logic hd, logic [1:0] s,
                                       logic [6:0] rem);
    step_row_t r;
    r.item.cmd       = c;
    r.item.value     = v;
    r.pinned         = p;
    r.want.data      = d;
    r.want.has_data  = hd;
    r.want.status    = s;
    r.want.remaining = rem;
    return r;
  endfunction

  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic out_item_t deque_step(in_item_t it);
    out_item_t  r;
    logic [5:0] slot;
    r = '0;
    r.status = ST_OK;
    if (it.cmd == CMD_CLEAR) begin
      base_ptr    = '0;
      fill_level  = '0;
      rev_mode    = 1'b0;
      err_latched = 1'b0;
    end else if (err_latched) begin
      r.status = ST_ERROR;
    end else begin
      case (it.cmd)
        CMD_LOAD: begin
          if (fill_level >= DEQUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot = base_ptr + fill_level[5:0];
            deque_mem[slot] = it.value;
            fill_level = fill_level + 7'd1;
          end
        end
        CMD_REVERSE: rev_mode = !rev_mode;
        CMD_DELETE, CMD_TAKE: begin
          if (fill_level == 0) begin
            if (it.cmd == CMD_DELETE) begin
              err_latched = 1'b1;
              r.status = ST_ERROR;
            end else begin
              r.status = ST_EMPTY;
            end
          end else begin
            if (rev_mode) begin
              slot = base_ptr + 6'(fill_level - 7'd1);
            end else begin
              slot = base_ptr;
              base_ptr = base_ptr + 6'd1;
            end
            fill_level = fill_level - 7'd1;
            if (it.cmd == CMD_TAKE) begin
              r.data = deque_mem[slot];
              r.has_data = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r.remaining = fill_level;
    return r;
  endfunction

  task automatic check_result(out_item_t want, out_item_t got);
    if (got.data !== want.data) begin
      $error("data: expected %h, actual %h", want.data, got.data);
      mismatches++;
    end
    if (got.has_data !== want.has_data) begin
      $error("has_data: expected %b, actual %b", want.has_data, got.has_data);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.remaining !== want.remaining) begin
      $error("remaining: expected %0d, actual %0d", want.remaining, got.remaining);
      mismatches++;
    end
  endtask

  task automatic send_item(step_row_t row);
    int gap;
    gap = draw_wait(source_run);
    sent_rows.insert(sent_rows.size(), row);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= row.item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_cmd(logic [2:0] c, logic [15:0] v);
    send_item(mk_row(c, v, 1'b0, '0, 1'b0, ST_OK, '0));
  endtask

  task automatic send_noise(int n);
    logic [2:0] c;
    repeat (n) begin
      c = 3'($urandom_range(0, 7));
      if (c == CMD_CLEAR && $urandom_range(0, 3) != 0) begin
        c = CMD_TAKE;
      end
      send_cmd(c, 16'($urandom_range(0, 65535)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        cur_row  = sent_rows[0];
        sent_rows.delete(0);
        cur_pred = deque_step(in_item);
        pending_results.insert(pending_results.size(),
                               cur_row.pinned ? cur_row.want : cur_pred);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing pending: %h", out_item);
          mismatches++;
        end else begin
          check_result(pending_results[0], out_item);
          pending_results.delete(0);
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = draw_wait(sink_run);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL reversible_deque_engine");
    $finish;
  end

  initial begin : stimulus
    int n;
    int pick;
    base_ptr    = '0;
    fill_level  = '0;
    rev_mode    = 1'b0;
    err_latched = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    directed_rows = '{
      mk_row(CMD_TAKE,      16'h0000, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 7'd0),
      mk_row(CMD_LOAD,      16'h0000, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd1),
      mk_row(CMD_LOAD,      16'hFFFF, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd2),
      mk_row(CMD_LOAD,      16'hA5A5, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd3),
      mk_row(CMD_REVERSE,   16'hFFFF, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd3),
      mk_row(CMD_TAKE,      16'h0000, 1'b1, 16'hA5A5, 1'b1, ST_OK,    7'd2),
      mk_row(CMD_REVERSE,   16'h0000, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd2),
      mk_row(CMD_TAKE,      16'hFFFF, 1'b1, 16'h0000, 1'b1, ST_OK,    7'd1),
      mk_row(CMD_LOAD,      16'h5A5A, 1'b0, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_REVERSE,   16'h0000, 1'b0, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_TAKE,      16'h0000, 1'b0, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_DELETE,    16'h0000, 1'b0, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_TAKE,      16'h0000, 1'b1, 16'h0000, 1'b0, ST_EMPTY, 7'd0),
      mk_row(CMD_SPARE_LO,  16'h8001, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_DELETE,    16'h0000, 1'b1, 16'h0000, 1'b0, ST_ERROR, 7'd0),
      mk_row(CMD_LOAD,      16'h1234, 1'b1, 16'h0000, 1'b0, ST_ERROR, 7'd0),
      mk_row(CMD_TAKE,      16'h0000, 1'b1, 16'h0000, 1'b0, ST_ERROR, 7'd0),
      mk_row(CMD_REVERSE,   16'h0000, 1'b1, 16'h0000, 1'b0, ST_ERROR, 7'd0),
      mk_row(CMD_SPARE_HI,  16'hFFFF, 1'b1, 16'h0000, 1'b0, ST_ERROR, 7'd0),
      mk_row(CMD_CLEAR,     16'hFFFF, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_SPARE_MID, 16'h7FFE, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd0),
      mk_row(CMD_LOAD,      16'hFFFF, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd1),
      mk_row(CMD_REVERSE,   16'h0000, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd1),
      mk_row(CMD_CLEAR,     16'h0000, 1'b1, 16'h0000, 1'b0, ST_OK,    7'd0)
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
    end

    while (items_sent < ITEM_TARGET) begin
      if (err_latched && $urandom_range(0, 1) == 0) begin
        send_cmd(CMD_CLEAR, 16'($urandom_range(0, 65535)));
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // fill phase, sometimes past full
        if ($urandom_range(0, 3) == 0) begin
          n = DEQUE_DEPTH + $urandom_range(0, 3);
        end else begin
          n = $urandom_range(1, 12);
        end
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            send_cmd(CMD_REVERSE, 16'($urandom_range(0, 65535)));
          end
          send_cmd(CMD_LOAD, 16'($urandom_range(0, 65535)));
        end
        // drain phase, sometimes one past empty
        if ($urandom_range(0, 3) == 0) begin
          n = fill_level + 1;
        end else begin
          n = $urandom_range(fill_level / 2, fill_level);
        end
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_cmd(CMD_REVERSE, 16'($urandom_range(0, 65535)));
          end
          if (fill_level == 0 || $urandom_range(0, 3) != 0) begin
            send_cmd(CMD_TAKE, 16'($urandom_range(0, 65535)));
          end else begin
            send_cmd(CMD_DELETE, 16'($urandom_range(0, 65535)));
          end
        end
      end else if (pick <= 7) begin
        send_noise($urandom_range(8, 24));
      end else if (pick == 8) begin
        repeat (fill_level + 1) send_cmd(CMD_DELETE, 16'($urandom_range(0, 65535)));
        send_noise($urandom_range(1, 5));
        send_cmd(CMD_CLEAR, 16'($urandom_range(0, 65535)));
      end else begin
        send_cmd(CMD_CLEAR, 16'($urandom_range(0, 65535)));
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS reversible_deque_engine");
    end else begin
      $display("FAIL reversible_deque_engine");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rde_pkg.sv
src/rde_store.sv
src/rde_ctrl.sv
src/rde_outq.sv
src/reversible_deque_engine.sv
src/rde_checker.sv
bench/tb_reversible_deque_engine.sv
